>>> design/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, quiet while reset is low
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, quiet while reset is low
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Delayed implication, sampled on i_clk, quiet while reset is low
`define ASSERT_AFTER2(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##2 (cons)) else $error(msg);

`endif

>>> design/bstk_pkg.sv
// Shared types and constants of the bounded stack with running extremes.
package bstk_pkg;

    // Capacity of the stack in words
    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Field widths of the command and result ports
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;

    // Command codes; the fourth code is a no-op
    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_READ = 2'd2
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

endpackage

>>> design/bstk_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bstk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/bounded_stack_with_extremes_core.sv
// Top level of the bounded LIFO stack that tracks running maximum and minimum.
//
//  channel   | direction | transfer when        | payload
//  ----------+-----------+----------------------+---------------------------------------
//  command   | in        | start && !busy       | i_cmd, i_push_value, i_read_index
//  result    | out       | o_done (one cycle)   | o_status, o_data_out, o_entry_count,
//            |           |                      | o_largest_value, o_smallest_value
//
//  Each command has an accept cycle, which issues the memory read, and an
//  execute cycle, which uses the read data and writes back the new level.
//  The result is strobed on o_done in the cycle after execute; busy is already
//  low then, so a new command can be taken in that same cycle.
//  Reset (synchronous, active low) empties the stack; the memories keep their
//  contents and read data is used only below the fill count. Results cannot be stalled.
module bounded_stack_with_extremes_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_cmd,
    input  logic signed [bstk_pkg::WORD_W-1:0]  i_push_value,
    input  logic [bstk_pkg::INDEX_W-1:0]  i_read_index,
    output logic                          o_done,
    output logic [1:0]                    o_status,
    output logic signed [bstk_pkg::WORD_W-1:0]  o_data_out,
    output logic [bstk_pkg::COUNT_W-1:0]  o_entry_count,
    output logic signed [bstk_pkg::WORD_W-1:0]  o_largest_value,
    output logic signed [bstk_pkg::WORD_W-1:0]  o_smallest_value
);

    import bstk_pkg::*;

    localparam int CMP_W = CNT_W + INDEX_W;

    t_state r_state, n_state;

    // Latched command
    logic [1:0]                r_cmd;
    logic signed [WORD_W-1:0]  r_val;
    logic [INDEX_W-1:0]        r_idx;

    // Fill count and cached extremes of the top level (zero when empty)
    logic [CNT_W-1:0]          r_count, n_count;
    logic signed [WORD_W-1:0]  r_top_max, n_top_max;
    logic signed [WORD_W-1:0]  r_top_min, n_top_min;

    // Result registers
    logic                      r_done;
    logic [1:0]                r_status, n_status;
    logic signed [WORD_W-1:0]  r_data, n_data;
    logic signed [WORD_W-1:0]  r_big, n_big;
    logic signed [WORD_W-1:0]  r_small, n_small;

    // Memory ports
    logic                      accept;
    logic                      ent_we, ext_we;
    logic [ADDR_W-1:0]         ent_raddr, ext_raddr, waddr;
    logic [WORD_W-1:0]         ent_rdata;
    logic [2*WORD_W-1:0]       ext_rdata, ext_wdata;

    // Execute-stage helpers
    logic signed [WORD_W-1:0]  push_hi, push_lo;
    logic                      is_full, is_empty, idx_ok;

    assign accept = start && !busy;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        case (r_state)
            ST_IDLE: busy = 1'b0;
            ST_EXEC: busy = 1'b1;
            default: busy = 1'b0;
        endcase
    end

    // Read addresses, issued in the accept cycle: the read index, or for pops and the extremes the current fill count
    always_comb begin
        if (i_cmd == CMD_POP) begin
            ent_raddr = ADDR_W'(r_count - CNT_W'(1));
        end else begin
            ent_raddr = ADDR_W'(i_read_index);
        end
        ext_raddr = ADDR_W'(r_count - CNT_W'(2));
    end

    // Execute-stage conditions and push extremes
    always_comb begin
        is_full  = (r_count == CNT_W'(STACK_DEPTH));
        is_empty = (r_count == '0);
        idx_ok   = ({{CNT_W{1'b0}}, r_idx} < {{INDEX_W{1'b0}}, r_count}) &&
                   ({{CNT_W{1'b0}}, r_idx} < CMP_W'(STACK_DEPTH));
        push_hi  = (!is_empty && (r_top_max > r_val)) ? r_top_max : r_val;
        push_lo  = (!is_empty && (r_top_min < r_val)) ? r_top_min : r_val;
    end

    // Execute datapath: result values and state updates
    always_comb begin
        n_count   = r_count;
        n_top_max = r_top_max;
        n_top_min = r_top_min;
        n_status  = STAT_OK;
        n_data    = '0;
        ent_we    = 1'b0;
        ext_we    = 1'b0;
        waddr     = ADDR_W'(r_count);
        ext_wdata = {push_hi, push_lo};
        case (r_cmd)
            CMD_PUSH: begin
                if (is_full) begin
                    n_status = STAT_FULL;
                end else begin
                    ent_we    = (r_state == ST_EXEC);
                    ext_we    = (r_state == ST_EXEC);
                    n_count   = r_count + CNT_W'(1);
                    n_top_max = push_hi;
                    n_top_min = push_lo;
                end
            end
            CMD_POP: begin
                if (is_empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_data  = ent_rdata;
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_top_max = '0;
                        n_top_min = '0;
                    end else begin
                        n_top_max = ext_rdata[2*WORD_W-1:WORD_W];
                        n_top_min = ext_rdata[WORD_W-1:0];
                    end
                end
            end
            CMD_READ: begin
                if (idx_ok) begin
                    n_data = ent_rdata;
                end else begin
                    n_status = STAT_RANGE;
                end
            end
            default: begin
                n_status = STAT_OK;
            end
        endcase
        n_big   = n_top_max;
        n_small = n_top_min;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_top_max <= '0;
            r_top_min <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_EXEC);
            if (r_state == ST_EXEC) begin
                r_count   <= n_count;
                r_top_max <= n_top_max;
                r_top_min <= n_top_min;
            end
        end
    end

    // Command latch and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
            r_val <= i_push_value;
            r_idx <= i_read_index;
        end
        if (r_state == ST_EXEC) begin
            r_status <= n_status;
            r_data   <= n_data;
            r_big    <= n_big;
            r_small  <= n_small;
        end
    end

    // Word store
    bstk_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (waddr),
        .i_wdata (r_val),
        .i_re    (accept),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    // Per-level running maximum and minimum, packed {max, min}
    bstk_ram #(
        .WIDTH (2 * WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_extreme_ram (
        .i_clk   (i_clk),
        .i_we    (ext_we),
        .i_waddr (waddr),
        .i_wdata (ext_wdata),
        .i_re    (accept),
        .i_raddr (ext_raddr),
        .o_rdata (ext_rdata)
    );

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_data_out       = r_data;
    assign o_entry_count    = COUNT_W'(r_count);
    assign o_largest_value  = r_big;
    assign o_smallest_value = r_small;

endmodule

>>> design/bstk_checker.sv
// Port-level checks of the bounded stack core, bound to the top level.
`include "assert_macros.svh"

module bstk_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          o_done,
    input  logic [1:0]                    o_status,
    input  logic [bstk_pkg::COUNT_W-1:0]  o_entry_count,
    input  logic signed [bstk_pkg::WORD_W-1:0]  o_largest_value,
    input  logic signed [bstk_pkg::WORD_W-1:0]  o_smallest_value
);

    import bstk_pkg::*;

    // Every accepted command yields its result on o_done after its execute cycle
    `ASSERT_AFTER2(a_result_follows, start && !busy, o_done, "command produced no result")

    // A result is shown only once the core is free again
    `ASSERT_IMPLIES(a_done_not_busy, o_done, !busy, "result shown while busy")

    // A full rejection reports a stack at capacity
    `ASSERT_IMPLIES(a_full_count, o_done && (o_status == STAT_FULL), o_entry_count == COUNT_W'(STACK_DEPTH), "full status with count below capacity")

    // An empty stack reports zero extremes, a non-empty one ordered extremes
    `ASSERT_IMPLIES(a_empty_zero, o_done && (o_entry_count == '0), (o_largest_value == '0) && (o_smallest_value == '0), "nonzero extremes on empty stack")
    `ASSERT_IMPLIES(a_extreme_order, o_done, o_largest_value >= o_smallest_value, "maximum below minimum")

endmodule

bind bounded_stack_with_extremes_core bstk_checker u_bstk_checker (.*);

>>> dv/tb_bounded_stack_with_extremes_core.sv
// Testbench for the bounded stack core: directed corner cases, then mixed random traffic.
`timescale 1ns / 1ps

module tb_bounded_stack_with_extremes_core;
    import bstk_pkg::*;

    // Fourth command code: no operation
    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int CYCLE_LIMIT = 100000;
    localparam int RANDOM_OPS  = 1550;
    localparam int PRINT_LIMIT = 40;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                i_cmd;
    logic signed [WORD_W-1:0]  i_push_value;
    logic [INDEX_W-1:0]        i_read_index;
    logic                      o_done;
    logic [1:0]                o_status;
    logic signed [WORD_W-1:0]  o_data_out;
    logic [COUNT_W-1:0]        o_entry_count;
    logic signed [WORD_W-1:0]  o_largest_value;
    logic signed [WORD_W-1:0]  o_smallest_value;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] data;
        logic [COUNT_W-1:0]       count;
        logic signed [WORD_W-1:0] largest;
        logic signed [WORD_W-1:0] smallest;
    } t_stack_result;

    // Shadow stack: words plus running extremes per level
    logic signed [WORD_W-1:0] shadow_words [STACK_DEPTH];
    logic signed [WORD_W-1:0] shadow_max   [STACK_DEPTH];
    logic signed [WORD_W-1:0] shadow_min   [STACK_DEPTH];
    int                       shadow_fill;

    t_stack_result pending_results[$];
    int            mismatch_count = 0;
    int            results_seen = 0;
    int            cycle_count = 0;
    bit            gaps_on;

    bounded_stack_with_extremes_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_push_value     (i_push_value),
        .i_read_index     (i_read_index),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_data_out       (o_data_out),
        .o_entry_count    (o_entry_count),
        .o_largest_value  (o_largest_value),
        .o_smallest_value (o_smallest_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t: result %0d %s: got %h, expected %h",
                     $realtime, results_seen, what, got, want);
        mismatch_count++;
    endtask

    // Next result of the stack for one command; updates the shadow stack
    function automatic t_stack_result apply_stack_op(input logic [1:0] cmd,
                                                     input logic signed [WORD_W-1:0] value,
                                                     input logic [INDEX_W-1:0] index);
        t_stack_result            res;
        logic signed [WORD_W-1:0] hi;
        logic signed [WORD_W-1:0] lo;
        res = '0;
        res.status = STAT_OK;
        case (cmd)
            CMD_PUSH: begin
                if (shadow_fill >= STACK_DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    hi = value;
                    lo = value;
                    if (shadow_fill > 0) begin
                        if (shadow_max[shadow_fill-1] > hi) hi = shadow_max[shadow_fill-1];
                        if (shadow_min[shadow_fill-1] < lo) lo = shadow_min[shadow_fill-1];
                    end
                    shadow_words[shadow_fill] = value;
                    shadow_max[shadow_fill]   = hi;
                    shadow_min[shadow_fill]   = lo;
                    shadow_fill++;
                end
            end
            CMD_POP: begin
                if (shadow_fill == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    shadow_fill--;
                    res.data = shadow_words[shadow_fill];
                end
            end
            CMD_READ: begin
                if (int'(index) >= shadow_fill) res.status = STAT_RANGE;
                else res.data = shadow_words[index];
            end
            default: ;
        endcase
        res.count = shadow_fill[COUNT_W-1:0];
        if (shadow_fill > 0) begin
            res.largest  = shadow_max[shadow_fill-1];
            res.smallest = shadow_min[shadow_fill-1];
        end
        return res;
    endfunction

    // One command transfer, with an optional random gap in front
    task automatic send_cmd(input logic [1:0] cmd, input logic signed [WORD_W-1:0] value,
                            input logic [INDEX_W-1:0] index);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(99) < 37) gap = $urandom_range(4, 1);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start        <= 1'b1;
        i_cmd        <= cmd;
        i_push_value <= value;
        i_read_index <= index;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(apply_stack_op(cmd, value, index));
    endtask

    task automatic release_start();
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    // Mix of extremes, small values and full-range words
    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return '0;
            3: return -32'sd1;
            4: return 32'sd9;
            5: return $signed($urandom_range(40)) - 32'sd20;
            default: return $signed($urandom);
        endcase
    endfunction

    // Result checker: every strobed result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_stack_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", {30'b0, o_status}, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", {30'b0, o_status}, {30'b0, want.status});
                if (o_data_out !== want.data)
                    report_mismatch("data_out", o_data_out, want.data);
                if (o_entry_count !== want.count)
                    report_mismatch("entry_count", {27'b0, o_entry_count}, {27'b0, want.count});
                if (o_largest_value !== want.largest)
                    report_mismatch("largest_value", o_largest_value, want.largest);
                if (o_smallest_value !== want.smallest)
                    report_mismatch("smallest_value", o_smallest_value, want.smallest);
            end
            results_seen++;
        end
    end

    // Pop, out-of-range read and no-op on the empty stack
    task automatic test_empty_stack();
        send_cmd(CMD_POP, 32'sh7FFF_FFFF, 4'd15);
        send_cmd(CMD_READ, '0, 4'd0);
        send_cmd(CMD_NOP, -32'sd1, 4'd15);
        send_cmd(CMD_READ, 32'sh8000_0000, 4'd15);
    endtask

    // Fill to capacity with extreme words, then push into a full stack
    task automatic test_fill_and_overflow();
        send_cmd(CMD_PUSH, 32'sd9, 4'd0);
        send_cmd(CMD_PUSH, -32'sd1, 4'd15);
        send_cmd(CMD_PUSH, 32'sh8000_0000, 4'd0);
        send_cmd(CMD_PUSH, 32'sh7FFF_FFFF, 4'd0);
        send_cmd(CMD_PUSH, '0, 4'd0);
        for (int i = 5; i < STACK_DEPTH; i++) send_cmd(CMD_PUSH, pick_word(), 4'($urandom));
        send_cmd(CMD_PUSH, 32'sh1234_5678, 4'd0);
    endtask

    // Reads at both ends of a full stack, then a pop and a read past the new top
    task automatic test_read_and_pop();
        send_cmd(CMD_READ, '0, 4'd0);
        send_cmd(CMD_READ, -32'sd1, 4'd15);
        send_cmd(CMD_POP, '0, 4'd0);
        send_cmd(CMD_READ, '0, 4'd15);
    endtask

    // Random traffic in segments that lean toward filling or draining the stack
    task automatic test_random_traffic();
        int push_w;
        int roll;
        logic [INDEX_W-1:0] index;
        push_w = 46;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(2))
                    0: push_w = 20;
                    1: push_w = 46;
                    default: push_w = 72;
                endcase
            end
            // long stretch with back-to-back commands
            gaps_on = !(n >= 600 && n < 900);
            roll = $urandom_range(99);
            if (shadow_fill > 0 && $urandom_range(3) != 0)
                index = INDEX_W'($urandom_range(shadow_fill - 1));
            else
                index = INDEX_W'($urandom);
            if (roll < 4)
                send_cmd(CMD_NOP, pick_word(), index);
            else if (roll < 4 + push_w)
                send_cmd(CMD_PUSH, pick_word(), index);
            else if (roll < 4 + push_w + (96 - push_w) / 2)
                send_cmd(CMD_POP, $signed($urandom), index);
            else
                send_cmd(CMD_READ, $signed($urandom), index);
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_cmd          = CMD_PUSH;
        i_push_value   = '0;
        i_read_index   = '0;
        shadow_fill    = 0;
        gaps_on        = 1'b1;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_stack();
        test_fill_and_overflow();
        test_read_and_pop();
        test_random_traffic();
        release_start();

        // drain outstanding results, then let the pipeline settle
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
